@@ rtl/afd_pkg.sv @@
// Shared types and constants for the 2D affine decomposition pipeline.
`default_nettype none
package afd_pkg;

  localparam int CORDIC_STEPS = 26;
  localparam int ROOT_STEPS   = 32;
  localparam int DIV_STEPS    = 32;

  // Stage map of the pipeline
  localparam int ST_PROD      = 1;
  localparam int ST_SUM       = 2;
  localparam int ST_CORDIC0   = 2;
  localparam int ST_ROUND     = ST_CORDIC0 + CORDIC_STEPS;
  localparam int ST_WRAP      = ST_ROUND + 1;
  localparam int ST_ROOT0     = 3;
  localparam int ST_DIV_INIT  = ST_ROOT0 + ROOT_STEPS;
  localparam int ST_DIV0      = ST_DIV_INIT + 1;
  localparam int ST_FINAL     = ST_DIV0 + DIV_STEPS;
  localparam int DEPTH        = ST_FINAL + 1;

  localparam int CW = 36;  // CORDIC x/y width
  localparam int ZW = 34;  // CORDIC angle accumulator width

  localparam logic signed [ZW-1:0] HALF_TURN = 34'sd3019898880;
  localparam logic signed [25:0]   FULL_TURN = 26'sd23592960;

  // atan(2^-i) in degrees, scaled by 2^24
  function automatic logic signed [ZW-1:0] atan_deg(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 34'sd754974720;
      1:  v = 34'sd445687602;
      2:  v = 34'sd235489088;
      3:  v = 34'sd119537938;
      4:  v = 34'sd60000934;
      5:  v = 34'sd30029717;
      6:  v = 34'sd15018523;
      7:  v = 34'sd7509720;
      8:  v = 34'sd3754917;
      9:  v = 34'sd1877466;
      10: v = 34'sd938734;
      11: v = 34'sd469367;
      12: v = 34'sd234684;
      13: v = 34'sd117342;
      14: v = 34'sd58671;
      15: v = 34'sd29335;
      16: v = 34'sd14668;
      17: v = 34'sd7334;
      18: v = 34'sd3667;
      19: v = 34'sd1833;
      20: v = 34'sd917;
      21: v = 34'sd458;
      22: v = 34'sd229;
      23: v = 34'sd115;
      24: v = 34'sd57;
      25: v = 34'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic [31:0]          px;
    logic [31:0]          py;
    logic signed [31:0]   bxx;
    logic signed [31:0]   bxy;
    logic signed [31:0]   byx;
    logic signed [31:0]   byy;
    logic                 zero_x;
    logic [63:0]          sq_xx;
    logic [63:0]          sq_xy;
    logic [63:0]          sq_yx;
    logic [63:0]          sq_yy;
    logic signed [63:0]   p1;
    logic signed [63:0]   p2;
    logic [63:0]          sum_x;
    logic [63:0]          sum_y;
    logic [63:0]          mag;
    logic [34:0]          rem_x;
    logic [31:0]          root_x;
    logic [34:0]          rem_y;
    logic [31:0]          root_y;
    logic [32:0]          drem;
    logic [31:0]          quo;
    logic                 sat;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] cz;
    logic signed [25:0]   cq;
    logic [24:0]          angle;
    logic [31:0]          sy;
  } pipe_t;

endpackage
`default_nettype wire

@@ rtl/affine_2d_decompose_top.sv @@
// Top level: pipelined decomposition of a 2D affine transform.
// Usage:
//   Input channel (in_valid / in_stall) takes one transform per item: two
//   basis columns and a translation, signed Q16.16.
//   Output channel (out_valid / out_stall) gives one result per item:
//   translation, angle in degrees (Q9.16, 0 to below 360), column length
//   and shear-free second length.
// Throughput: one item per cycle while the output is not stalled. The
//   depth is set by the 32-step root and the 32-step divide that follows
//   it; the 26-step CORDIC runs beside the root.
// Reset (rst, synchronous) clears all valid bits; no payload is cleared.
// When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall rises; nothing is dropped or repeated. Bubbles are not
//   squeezed out while the output is held.
`default_nettype none
module affine_2d_decompose_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] basis_x_x,
  input  wire logic [31:0] basis_x_y,
  input  wire logic [31:0] basis_y_x,
  input  wire logic [31:0] basis_y_y,
  input  wire logic [31:0] offset_x,
  input  wire logic [31:0] offset_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      position_x,
  output logic [31:0]      position_y,
  output logic [24:0]      angle_degrees,
  output logic [31:0]      stretch_x,
  output logic [31:0]      stretch_y
);

  localparam int L = afd_pkg::DEPTH;

  logic           valid [0:L-1];
  afd_pkg::pipe_t pipe  [0:L-1];
  afd_pkg::pipe_t head;
  logic           ce;

  assign ce       = !(valid[L-1] && out_stall);
  assign in_stall = !ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (ce) begin
      valid[0] <= in_valid;
    end
  end

  always_comb begin
    head        = '0;
    head.px     = offset_x;
    head.py     = offset_y;
    head.bxx    = basis_x_x;
    head.bxy    = basis_x_y;
    head.byx    = basis_y_x;
    head.byy    = basis_y_y;
    head.zero_x = (basis_x_x == 32'd0) && (basis_x_y == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pipe[0] <= head;
    end
  end

  for (genvar r = 1; r < L; r++) begin : g_stage
    localparam int CWL = afd_pkg::CW;
    // bit positions used by this stage, held in range where unused
    localparam int CS = (r >= afd_pkg::ST_CORDIC0 && r < afd_pkg::ST_ROUND) ?
                        r - afd_pkg::ST_CORDIC0 : 0;
    localparam int RB = (r >= afd_pkg::ST_ROOT0 && r < afd_pkg::ST_DIV_INIT) ?
                        2*(afd_pkg::ST_DIV_INIT-1-r)+1 : 1;
    localparam int DB = (r >= afd_pkg::ST_DIV0 && r < afd_pkg::ST_FINAL) ?
                        afd_pkg::ST_FINAL-1-r : 0;
    afd_pkg::pipe_t       nxt;
    logic signed [63:0]   d1;
    logic signed [63:0]   d2;
    logic signed [64:0]   dd;
    logic [34:0]          tx;
    logic [34:0]          ty;
    logic [34:0]          trx;
    logic [34:0]          try_v;
    logic signed [CWL-1:0] dx;
    logic signed [CWL-1:0] dy;
    logic signed [afd_pkg::ZW-1:0] zr;
    logic [32:0]          dn;

    always_comb begin
      nxt   = pipe[r-1];
      d1    = '0;
      d2    = '0;
      dd    = '0;
      tx    = '0;
      ty    = '0;
      trx   = '0;
      try_v = '0;
      dx    = '0;
      dy    = '0;
      zr    = '0;
      dn    = '0;

      if (r == afd_pkg::ST_PROD) begin
        nxt.sq_xx = 64'(pipe[r-1].bxx * pipe[r-1].bxx);
        nxt.sq_xy = 64'(pipe[r-1].bxy * pipe[r-1].bxy);
        nxt.sq_yx = 64'(pipe[r-1].byx * pipe[r-1].byx);
        nxt.sq_yy = 64'(pipe[r-1].byy * pipe[r-1].byy);
        d1 = pipe[r-1].bxx * pipe[r-1].byy;
        d2 = pipe[r-1].bxy * pipe[r-1].byx;
        nxt.p1 = d1;
        nxt.p2 = d2;
        // fold the left half plane over to the right
        if (pipe[r-1].bxx[31]) begin
          nxt.cx = -CWL'(pipe[r-1].bxx);
          nxt.cy = -CWL'(pipe[r-1].bxy);
          nxt.cz = afd_pkg::HALF_TURN;
        end else begin
          nxt.cx = CWL'(pipe[r-1].bxx);
          nxt.cy = CWL'(pipe[r-1].bxy);
          nxt.cz = '0;
        end
      end

      if (r == afd_pkg::ST_SUM) begin
        nxt.sum_x = pipe[r-1].sq_xx + pipe[r-1].sq_xy;
        nxt.sum_y = pipe[r-1].sq_yx + pipe[r-1].sq_yy;
        dd = 65'(pipe[r-1].p1) - 65'(pipe[r-1].p2);
        nxt.mag = dd[64] ? 64'(65'(pipe[r-1].p2) - 65'(pipe[r-1].p1)) : dd[63:0];
        nxt.rem_x  = '0;
        nxt.root_x = '0;
        nxt.rem_y  = '0;
        nxt.root_y = '0;
      end

      if (r >= afd_pkg::ST_CORDIC0 && r < afd_pkg::ST_ROUND) begin
        dx = pipe[r-1].cy >>> CS;
        dy = pipe[r-1].cx >>> CS;
        if (!pipe[r-1].cy[CWL-1]) begin
          nxt.cx = pipe[r-1].cx + dx;
          nxt.cy = pipe[r-1].cy - dy;
          nxt.cz = pipe[r-1].cz + afd_pkg::atan_deg(CS);
        end else begin
          nxt.cx = pipe[r-1].cx - dx;
          nxt.cy = pipe[r-1].cy + dy;
          nxt.cz = pipe[r-1].cz - afd_pkg::atan_deg(CS);
        end
      end

      if (r == afd_pkg::ST_ROUND) begin
        zr = pipe[r-1].cz + afd_pkg::ZW'(128);
        nxt.cq = 26'(zr >>> 8);
      end

      if (r == afd_pkg::ST_WRAP) begin
        if (pipe[r-1].zero_x) begin
          nxt.angle = '0;
        end else if (pipe[r-1].cq < 0) begin
          nxt.angle = 25'(pipe[r-1].cq + afd_pkg::FULL_TURN);
        end else if (pipe[r-1].cq >= afd_pkg::FULL_TURN) begin
          nxt.angle = 25'(pipe[r-1].cq - afd_pkg::FULL_TURN);
        end else begin
          nxt.angle = 25'(pipe[r-1].cq);
        end
      end

      // one root bit per stage for both columns
      if (r >= afd_pkg::ST_ROOT0 && r < afd_pkg::ST_DIV_INIT) begin
        tx    = {pipe[r-1].rem_x[32:0], pipe[r-1].sum_x[RB -: 2]};
        ty    = {pipe[r-1].rem_y[32:0], pipe[r-1].sum_y[RB -: 2]};
        trx   = {1'b0, pipe[r-1].root_x, 2'b01};
        try_v = {1'b0, pipe[r-1].root_y, 2'b01};
        if (tx >= trx) begin
          nxt.rem_x  = tx - trx;
          nxt.root_x = {pipe[r-1].root_x[30:0], 1'b1};
        end else begin
          nxt.rem_x  = tx;
          nxt.root_x = {pipe[r-1].root_x[30:0], 1'b0};
        end
        if (ty >= try_v) begin
          nxt.rem_y  = ty - try_v;
          nxt.root_y = {pipe[r-1].root_y[30:0], 1'b1};
        end else begin
          nxt.rem_y  = ty;
          nxt.root_y = {pipe[r-1].root_y[30:0], 1'b0};
        end
      end

      if (r == afd_pkg::ST_DIV_INIT) begin
        nxt.drem = {1'b0, pipe[r-1].mag[63:32]};
        nxt.sat  = pipe[r-1].mag[63:32] >= pipe[r-1].root_x;
        nxt.quo  = '0;
      end

      // restoring divide, one quotient bit per stage
      if (r >= afd_pkg::ST_DIV0 && r < afd_pkg::ST_FINAL) begin
        dn = {pipe[r-1].drem[31:0], pipe[r-1].mag[DB]};
        if (dn >= {1'b0, pipe[r-1].root_x}) begin
          nxt.drem = dn - {1'b0, pipe[r-1].root_x};
          nxt.quo  = {pipe[r-1].quo[30:0], 1'b1};
        end else begin
          nxt.drem = dn;
          nxt.quo  = {pipe[r-1].quo[30:0], 1'b0};
        end
      end

      if (r == afd_pkg::ST_FINAL) begin
        if (pipe[r-1].zero_x) begin
          nxt.sy = pipe[r-1].root_y;
        end else if (pipe[r-1].sat) begin
          nxt.sy = '1;
        end else begin
          nxt.sy = pipe[r-1].quo;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[r] <= 1'b0;
      end else if (ce) begin
        valid[r] <= valid[r-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        pipe[r] <= nxt;
      end
    end
  end

  assign out_valid     = valid[L-1];
  assign position_x    = pipe[L-1].px;
  assign position_y    = pipe[L-1].py;
  assign angle_degrees = pipe[L-1].angle;
  assign stretch_x     = pipe[L-1].root_x;
  assign stretch_y     = pipe[L-1].sy;

endmodule
`default_nettype wire

@@ test/affine_2d_decompose_top_test.sv @@
// Self-checking testbench for the 2D affine decomposition pipeline.
`default_nettype none
module affine_2d_decompose_top_test;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [24:0] angle;
    logic [31:0] len_x;
    logic [31:0] len_y;
  } decomp_t;

  localparam longint HALF_TURN_Q24 = 64'sd3019898880;
  localparam longint FULL_TURN_Q16 = 64'sd23592960;
  localparam int     ROTATE_STEPS  = 26;
  localparam longint ATAN_Q24 [ROTATE_STEPS] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
  localparam int PIPE_LATENCY = 68;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] basis_x_x = '0;
  logic [31:0] basis_x_y = '0;
  logic [31:0] basis_y_x = '0;
  logic [31:0] basis_y_y = '0;
  logic [31:0] offset_x = '0;
  logic [31:0] offset_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] position_x;
  logic [31:0] position_y;
  logic [24:0] angle_degrees;
  logic [31:0] stretch_x;
  logic [31:0] stretch_y;

  decomp_t pending_results[$];
  int      fail_count = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  int      saw_in_stall = 0;
  int      sender_gaps = 1;
  int      receiver_stalls = 1;
  int      hold_left = 0;

  affine_2d_decompose_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .basis_x_x(basis_x_x), .basis_x_y(basis_x_y),
    .basis_y_x(basis_y_x), .basis_y_y(basis_y_y),
    .offset_x(offset_x), .offset_y(offset_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .position_x(position_x), .position_y(position_y),
    .angle_degrees(angle_degrees), .stretch_x(stretch_x), .stretch_y(stretch_y)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [24:0] column_angle(longint x, longint y);
    longint z;
    longint dx;
    longint dy;
    longint q;
    z = 0;
    // fold the left half plane onto the right one
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN_Q24;
    end
    for (int i = 0; i < ROTATE_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += ATAN_Q24[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_Q24[i];
      end
    end
    q = (z + 128) >>> 8;
    if (q < 0) q += FULL_TURN_Q16;
    else if (q >= FULL_TURN_Q16) q -= FULL_TURN_Q16;
    return q[24:0];
  endfunction

  function automatic decomp_t decompose(logic [31:0] a, b, c, d, ox, oy);
    decomp_t res;
    longint bxx;
    longint bxy;
    longint byx;
    longint byy;
    longint p1;
    longint p2;
    logic [63:0] sq;
    logic [63:0] lx;
    logic [63:0] mag;
    logic [63:0] quot;
    bxx = longint'($signed(a));
    bxy = longint'($signed(b));
    byx = longint'($signed(c));
    byy = longint'($signed(d));
    sq = 64'(bxx * bxx);
    sq = sq + 64'(bxy * bxy);
    lx = floor_root(sq);
    res.pos_x = ox;
    res.pos_y = oy;
    res.len_x = lx[31:0];
    res.angle = '0;
    if (lx == 0) begin
      sq = 64'(byx * byx);
      sq = sq + 64'(byy * byy);
      quot = floor_root(sq);
      res.len_y = quot[31:0];
    end else begin
      p1 = bxx * byy;
      p2 = bxy * byx;
      mag = (p1 >= p2) ? 64'(p1 - p2) : 64'(p2 - p1);
      quot = mag / lx;
      res.len_y = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
      res.angle = column_angle(bxx, bxy);
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Call at a falling edge; returns at the falling edge after the accept.
  task automatic send_transform(logic [31:0] a, b, c, d, ox, oy);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    basis_x_x = a;
    basis_x_y = b;
    basis_y_x = c;
    basis_y_y = d;
    offset_x = ox;
    offset_y = oy;
    in_valid = 1'b1;
    do begin
      @(posedge clk);
      if (in_stall) saw_in_stall++;
    end while (in_stall);
    pending_results.insert(pending_results.size(), decompose(a, b, c, d, ox, oy));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_component();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2: return $urandom();
      3, 4, 5: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      6: return 32'($signed($urandom_range(0, 64)) - 32);
      7: begin
        case ($urandom_range(0, 5))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0;
          3: return 32'hFFFF_FFFF;
          4: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
    endcase
  endfunction

  task automatic send_random_transform();
    logic [31:0] a;
    logic [31:0] b;
    a = rand_component();
    b = rand_component();
    // make the zero first column show up now and then
    if ($urandom_range(0, 19) == 0) begin
      a = '0;
      b = '0;
    end
    send_transform(a, b, rand_component(), rand_component(), $urandom(), $urandom());
  endtask

  task automatic test_directed_cases();
    // identity, rotations on the axes and both diagonals
    send_transform(32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0012_3456, 32'hFFED_CBAA);
    send_transform(0, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0);
    send_transform(32'hFFFF_0000, 0, 0, 32'hFFFF_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_transform(0, 32'hFFFF_0000, 32'h0001_0000, 0, 32'hFFFF_FFFF, 1);
    send_transform(32'h0001_0000, 32'h0001_0000, 0, 32'h0002_0000, 0, 0);
    send_transform(32'hFFFF_0000, 32'h0001_0000, 1, 1, 0, 0);
    send_transform(32'hFFFF_0000, 32'hFFFF_0000, 5, 7, 0, 0);
    send_transform(32'h0001_0000, 32'hFFFF_FFFF, 3, 3, 0, 0);
    // tiny negative angle wraps to just under a full turn
    send_transform(32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1, 0, 0);
    // zero first column: length of the second column instead
    send_transform(0, 0, 32'h0003_0000, 32'h0004_0000, 0, 0);
    send_transform(0, 0, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send_transform(0, 0, 0, 0, 0, 0);
    // extremes of the first column
    send_transform(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send_transform(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    send_transform(32'h8000_0000, 0, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send_transform(32'h8000_0000, 1, 0, 32'h7FFF_FFFF, 0, 0);
    // shortest column against largest determinant, right at the clamp
    send_transform(1, 1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    send_transform(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send_transform(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    send_transform(2, 3, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    // parallel columns give a zero determinant
    send_transform(32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0006_0000, 0, 0);
    drain();
  endtask

  task automatic test_random_stream();
    for (int n = 0; n < 1500; n++) begin
      // alternate stretches of free flow with stretches of idling
      if (n % 250 == 0) begin
        sender_gaps = (n % 500 == 0);
        receiver_stalls = (n % 500 == 0);
      end
      send_random_transform();
    end
    drain();
  endtask

  task automatic test_output_hold_off();
    sender_gaps = 0;
    receiver_stalls = 0;
    hold_left = 300;
    for (int n = 0; n < 90; n++) send_random_transform();
    receiver_stalls = 1;
    sender_gaps = 1;
    drain();
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_stall = 1'b0;
    end else if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (receiver_stalls) begin
      case ($urandom_range(0, 99)) inside
        [0:69]:  out_stall = 1'b0;
        [70:96]: out_stall = 1'b1;
        default: begin
          out_stall = 1'b1;
          hold_left = $urandom_range(10, 40);
        end
      endcase
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    decomp_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (position_x !== exp_res.pos_x) begin
          $error("position_x expected %h got %h", exp_res.pos_x, position_x);
          fail_count++;
        end
        if (position_y !== exp_res.pos_y) begin
          $error("position_y expected %h got %h", exp_res.pos_y, position_y);
          fail_count++;
        end
        if (angle_degrees !== exp_res.angle) begin
          $error("angle_degrees expected %h got %h", exp_res.angle, angle_degrees);
          fail_count++;
        end
        if (stretch_x !== exp_res.len_x) begin
          $error("stretch_x expected %h got %h", exp_res.len_x, stretch_x);
          fail_count++;
        end
        if (stretch_y !== exp_res.len_y) begin
          $error("stretch_y expected %h got %h", exp_res.len_y, stretch_y);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_cases();
    test_random_stream();
    test_output_hold_off();
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    $display("Sent %0d transforms, checked %0d results; input held off %0d cycles.",
             items_sent, results_seen, saw_in_stall);
    $display("Covered axis and diagonal angles, zero first column, clamp edge, full range.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/afd_pkg.sv
rtl/affine_2d_decompose_top.sv
test/affine_2d_decompose_top_test.sv
